// File: hw/rtl/uam_pkg.sv
// ----------------------------------------------------------------------------
// uam_pkg
// Shared types and constants for the receiver acknowledgement matcher.
// ----------------------------------------------------------------------------
package uam_pkg;

  localparam int unsigned PktLen = 10;
  localparam int unsigned IdxW   = 4;

  localparam logic [7:0] HdrSync1 = 8'hB5;
  localparam logic [7:0] HdrSync2 = 8'h62;
  localparam logic [7:0] AckClass = 8'h05;
  localparam logic [7:0] AckId    = 8'h01;
  localparam logic [7:0] AckLenLo = 8'h02;
  localparam logic [7:0] AckLenHi = 8'h00;

  localparam logic [IdxW-1:0] IdxLast = IdxW'(PktLen - 1);
  localparam logic [IdxW-1:0] IdxDone = IdxW'(PktLen);

  localparam logic [15:0] TickMax = 16'hFFFF;

  localparam logic [7:0]  RstAckedClass   = 8'd6;
  localparam logic [7:0]  RstAckedId      = 8'd1;
  localparam logic [15:0] RstTimeoutTicks = 16'd3000;

  // wait phase codes
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhWait = 2'd1;
  localparam logic [1:0] PhAck  = 2'd2;
  localparam logic [1:0] PhFail = 2'd3;

  // configuration register indexes
  localparam logic [1:0] RegAckedClass   = 2'd0;
  localparam logic [1:0] RegAckedId      = 2'd1;
  localparam logic [1:0] RegTimeoutTicks = 2'd2;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } uam_action_e;

  typedef struct packed {
    logic [1:0]      phase;
    logic [IdxW-1:0] index;
  } uam_status_t;

endpackage

// File: hw/rtl/uam_in_if.sv
// ----------------------------------------------------------------------------
// uam_in_if
// Input item channel: action code and received byte.
// ----------------------------------------------------------------------------
interface uam_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// File: hw/rtl/uam_out_if.sv
// ----------------------------------------------------------------------------
// uam_out_if
// Result item channel: wait status and matched byte count.
// ----------------------------------------------------------------------------
interface uam_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] wait_status;
  logic [3:0] matched_bytes;

  modport source (output valid, output wait_status, output matched_bytes, input ready);
  modport sink   (input valid, input wait_status, input matched_bytes, output ready);
endinterface

// File: hw/rtl/uam_expect.sv
// ----------------------------------------------------------------------------
// uam_expect
// Expected packet byte at a match index, with Fletcher-8 check bytes.
// ----------------------------------------------------------------------------
module uam_expect import uam_pkg::*; (
  input  logic [IdxW-1:0] index_i,
  input  logic [7:0]      acked_class_i,
  input  logic [7:0]      acked_id_i,
  output logic [7:0]      byte_o
);

  logic [7:0] ck_a_fix;
  logic [7:0] ck_b_fix;
  logic [7:0] ck_a;
  logic [7:0] ck_b;

  // fixed part of the running sums over class, id and length bytes
  assign ck_a_fix = AckClass + AckId + AckLenLo + AckLenHi;
  assign ck_b_fix = 8'(4 * AckClass + 3 * AckId + 2 * AckLenLo + AckLenHi);

  assign ck_a = ck_a_fix + acked_class_i + acked_id_i;
  assign ck_b = ck_b_fix + ck_a_fix + ck_a_fix + {acked_class_i[6:0], 1'b0} + acked_id_i;

  always_comb begin
    case (index_i)
      4'd0:    byte_o = HdrSync1;
      4'd1:    byte_o = HdrSync2;
      4'd2:    byte_o = AckClass;
      4'd3:    byte_o = AckId;
      4'd4:    byte_o = AckLenLo;
      4'd5:    byte_o = AckLenHi;
      4'd6:    byte_o = acked_class_i;
      4'd7:    byte_o = acked_id_i;
      4'd8:    byte_o = ck_a;
      4'd9:    byte_o = ck_b;
      default: byte_o = 8'h00;
    endcase
  end

endmodule

// File: hw/rtl/uam_step.sv
// ----------------------------------------------------------------------------
// uam_step
// Wait state registers and the per-item update of phase, index and ticks.
// ----------------------------------------------------------------------------
module uam_step import uam_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  acked_class_i,
  input  logic [7:0]  acked_id_i,
  input  logic [15:0] timeout_ticks_i,
  output uam_status_t status_d_o
);

  logic [1:0]      phase_q, phase_d;
  logic [IdxW-1:0] index_q, index_d;
  logic [15:0]     elapsed_q, elapsed_d;
  logic [15:0]     elapsed_inc;
  logic [7:0]      exp_byte;

  uam_expect u_expect (
    .index_i       (index_q),
    .acked_class_i (acked_class_i),
    .acked_id_i    (acked_id_i),
    .byte_o        (exp_byte)
  );

  assign elapsed_inc = (elapsed_q != TickMax) ? elapsed_q + 16'd1 : elapsed_q;

  always_comb begin
    phase_d   = phase_q;
    index_d   = index_q;
    elapsed_d = elapsed_q;
    case (action_i)
      ACT_START: begin
        phase_d   = PhWait;
        index_d   = '0;
        elapsed_d = '0;
      end
      ACT_BYTE: begin
        if (phase_q == PhWait) begin
          if (index_q <= IdxLast && rx_byte_i == exp_byte) begin
            index_d = index_q + 1'b1;
            if (index_q == IdxLast) begin
              phase_d = PhAck;
            end
          end else begin
            index_d = '0;
          end
        end
      end
      ACT_TICK: begin
        if (phase_q == PhWait) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc > timeout_ticks_i) begin
            phase_d = PhFail;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      index_q   <= '0;
      elapsed_q <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      index_q   <= index_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign status_d_o.phase = phase_d;
  assign status_d_o.index = index_d;

endmodule

// File: hw/rtl/ubx_ack_matcher.sv
// ----------------------------------------------------------------------------
// ubx_ack_matcher
// Waits for a receiver acknowledgement packet with timeout on tick items.
// Throughput: one item per cycle while the output is not stalled; the input
// register feeds the state update, whose result lands in an output register.
// Reset: state idle, index and ticks zero, registers at their defaults.
// ----------------------------------------------------------------------------
module ubx_ack_matcher import uam_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  uam_in_if.sink        in_i,
  uam_out_if.source     out_o
);

  logic [7:0]  acked_class_q;
  logic [7:0]  acked_id_q;
  logic [15:0] timeout_ticks_q;

  logic        in_valid_q;
  logic [1:0]  in_action_q;
  logic [7:0]  in_byte_q;

  logic        out_valid_q;
  uam_status_t out_q;
  uam_status_t status_d;

  logic adv;
  logic fire;

  assign adv  = !out_valid_q || out_o.ready;
  assign fire = in_valid_q && adv;
  assign in_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acked_class_q   <= RstAckedClass;
      acked_id_q      <= RstAckedId;
      timeout_ticks_q <= RstTimeoutTicks;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegAckedClass:   acked_class_q   <= cfg_data_i[7:0];
        RegAckedId:      acked_id_q      <= cfg_data_i[7:0];
        RegTimeoutTicks: timeout_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_action_q <= in_i.action;
      in_byte_q   <= in_i.rx_byte;
    end
    if (fire) begin
      out_q <= status_d;
    end
  end

  uam_step u_step (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .action_i        (in_action_q),
    .rx_byte_i       (in_byte_q),
    .acked_class_i   (acked_class_q),
    .acked_id_i      (acked_id_q),
    .timeout_ticks_i (timeout_ticks_q),
    .status_d_o      (status_d)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.wait_status   = out_q.phase;
  assign out_o.matched_bytes = out_q.index;

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.index <= IdxDone)
    else $error("matched count beyond packet length");

  a_ack_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.phase == PhAck) |-> out_q.index == IdxDone)
    else $error("acknowledged without full packet");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.phase == PhIdle) |-> out_q.index == '0)
    else $error("idle with nonzero match count");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_action_q == ACT_START) |=>
      (out_valid_q && out_q.phase == PhWait && out_q.index == '0))
    else $error("start item did not arm a clean wait");

endmodule

// File: dv/ack_status_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ack_status_checker
// Watches the item channels and the register port of the acknowledgement
// matcher, tracks packet index, tick count and wait phase on its own, and
// compares every result item against the status predicted for its input item.
// ----------------------------------------------------------------------------
module ack_status_checker import uam_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  uam_in_if           in_mon_i,
  uam_out_if          out_mon_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [7:0]      acked_class_r;
  logic [7:0]      acked_id_r;
  logic [15:0]     timeout_r;
  logic [IdxW-1:0] match_idx;
  logic [15:0]     tick_cnt;
  logic [1:0]      wait_ph;
  uam_status_t     want_status_q[$];

  function automatic logic [7:0] ack_byte(input logic [IdxW-1:0] pos);
    logic [7:0] pkt [PktLen];
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    pkt[0] = HdrSync1;
    pkt[1] = HdrSync2;
    pkt[2] = AckClass;
    pkt[3] = AckId;
    pkt[4] = AckLenLo;
    pkt[5] = AckLenHi;
    pkt[6] = acked_class_r;
    pkt[7] = acked_id_r;
    sum_a = '0;
    sum_b = '0;
    for (int k = 2; k < 8; k++) begin
      sum_a += pkt[k];
      sum_b += sum_a;
    end
    pkt[8] = sum_a;
    pkt[9] = sum_b;
    return (pos < IdxDone) ? pkt[pos] : 8'h00;
  endfunction

  function automatic void advance_matcher(input logic [1:0] act, input logic [7:0] rx);
    case (act)
      ACT_START: begin
        match_idx = '0;
        tick_cnt  = '0;
        wait_ph   = PhWait;
      end
      ACT_BYTE: begin
        if (wait_ph == PhWait) begin
          if (match_idx < IdxDone && rx == ack_byte(match_idx)) begin
            match_idx++;
            if (match_idx == IdxDone) wait_ph = PhAck;
          end else begin
            match_idx = '0;
          end
        end
      end
      ACT_TICK: begin
        if (wait_ph == PhWait) begin
          if (tick_cnt != TickMax) tick_cnt++;
          if (tick_cnt > timeout_r) wait_ph = PhFail;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    uam_status_t want;
    if (!rst_ni) begin
      acked_class_r = RstAckedClass;
      acked_id_r    = RstAckedId;
      timeout_r     = RstTimeoutTicks;
      match_idx     = '0;
      tick_cnt      = '0;
      wait_ph       = PhIdle;
      want_status_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegAckedClass:   acked_class_r = cfg_data_i[7:0];
          RegAckedId:      acked_id_r    = cfg_data_i[7:0];
          RegTimeoutTicks: timeout_r     = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        advance_matcher(in_mon_i.action, in_mon_i.rx_byte);
        want.phase = wait_ph;
        want.index = match_idx;
        want_status_q.push_back(want);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (want_status_q.size() == 0) begin
          report_mismatch("result item with no item pending");
        end else begin
          want = want_status_q.pop_front();
          if (out_mon_i.wait_status !== want.phase)
            report_mismatch($sformatf("wait_status got %0d expected %0d",
                                      out_mon_i.wait_status, want.phase));
          if (out_mon_i.matched_bytes !== want.index)
            report_mismatch($sformatf("matched_bytes got %0d expected %0d",
                                      out_mon_i.matched_bytes, want.index));
        end
      end
      pending_o <= want_status_q.size();
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the acknowledgement matcher with directed packets, then phases of
// random packet attempts, stray bytes and ticks under several register
// settings, with random stalls on both channels; a run at the widest timeout
// and a long output hold are included. Results are checked by ack_status_checker.
// ----------------------------------------------------------------------------
module testbench;
  import uam_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam logic [1:0] RegUnused = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          items_sent;
  bit          calm;
  logic        hold_req;
  int          hold_left;
  logic [7:0]  cur_cls;
  logic [7:0]  cur_id;

  uam_in_if  in_ch ();
  uam_out_if out_ch ();

  ubx_ack_matcher uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  ack_status_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // output side: random stalls, plus a long hold on request
  initial begin
    hold_req = 1'b0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pkt_byte(input int pos);
    logic [7:0] pkt [PktLen];
    logic [7:0] fa;
    logic [7:0] fb;
    pkt[0] = HdrSync1;
    pkt[1] = HdrSync2;
    pkt[2] = AckClass;
    pkt[3] = AckId;
    pkt[4] = AckLenLo;
    pkt[5] = AckLenHi;
    pkt[6] = cur_cls;
    pkt[7] = cur_id;
    fa = '0;
    fb = '0;
    for (int k = 2; k < 8; k++) begin
      fa += pkt[k];
      fb += fa;
    end
    pkt[8] = fa;
    pkt[9] = fb;
    return pkt[pos];
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [7:0] rx);
    while (!calm && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.rx_byte <= rx;
    do @(posedge clk); while (!in_ch.ready);
    if (act != ActUnused) items_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] cls, input logic [7:0] id,
                          input logic [15:0] tmo);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= RegAckedClass;
    cfg_data <= {rnd8(), cls};
    @(posedge clk);
    cfg_idx  <= RegAckedId;
    cfg_data <= {rnd8(), id};
    @(posedge clk);
    cfg_idx  <= RegUnused;
    cfg_data <= {rnd8(), rnd8()};
    @(posedge clk);
    cfg_idx  <= RegTimeoutTicks;
    cfg_data <= tmo;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_cls = cls;
    cur_id  = id;
  endtask

  task automatic try_packet();
    int  bad_at;
    bit  quit;
    if ($urandom_range(9) < 8) send_item(ACT_START, rnd8());
    bad_at = ($urandom_range(2) == 0) ? $urandom_range(PktLen - 1) : PktLen;
    quit = 1'b0;
    for (int p = 0; p < PktLen && !quit; p++) begin
      if ($urandom_range(99) < 6) send_item(ACT_TICK, rnd8());
      if (p == bad_at) begin
        send_item(ACT_BYTE, rnd8());
        quit = 1'($urandom_range(1));
      end else begin
        send_item(ACT_BYTE, pkt_byte(p));
      end
    end
  endtask

  task automatic run_mix(input int n);
    int stop_at;
    int kind;
    int reps;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        try_packet();
      end else if (kind < 72) begin
        reps = $urandom_range(1, 8);
        repeat (reps) send_item(ACT_TICK, rnd8());
      end else if (kind < 87) begin
        reps = $urandom_range(1, 5);
        repeat (reps) send_item(ACT_BYTE, rnd8());
      end else if (kind < 95) begin
        send_item(ACT_START, rnd8());
      end else begin
        send_item(2'($urandom_range(3)), rnd8());
      end
    end
  endtask

  initial begin
    int wait_cnt;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= RegAckedClass;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_START;
    in_ch.rx_byte <= '0;
    calm       = 1'b0;
    items_sent = 0;
    cur_cls    = RstAckedClass;
    cur_id     = RstAckedId;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle: bytes, ticks and the unused action are ignored
    send_item(ACT_BYTE, HdrSync1);
    send_item(ACT_TICK, 8'hFF);
    send_item(ActUnused, 8'h00);
    // full packet with the reset registers
    send_item(ACT_START, 8'h00);
    for (int p = 0; p < PktLen; p++) send_item(ACT_BYTE, pkt_byte(p));
    send_item(ACT_BYTE, 8'hFF);
    // mismatch on a header byte is not retried as a new start
    send_item(ACT_START, 8'hA5);
    send_item(ACT_BYTE, HdrSync1);
    send_item(ACT_BYTE, HdrSync2);
    send_item(ACT_BYTE, HdrSync1);
    send_item(ActUnused, 8'hFF);
    send_item(ACT_BYTE, HdrSync1);
    // restart in the middle of a packet
    send_item(ACT_START, 8'h5A);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_BYTE, HdrSync1);

    set_regs(8'h00, 8'h00, 16'h0000);
    run_mix(100);

    set_regs(8'hFF, 8'hFF, 16'h0001);
    hold_req <= 1'b1;
    run_mix(100);

    // widest timeout: ticks keep the wait open, then a full packet
    set_regs(rnd8(), rnd8(), 16'hFFFF);
    calm = 1'b1;
    send_item(ACT_START, rnd8());
    repeat (40) send_item(ACT_TICK, rnd8());
    for (int p = 0; p < PktLen; p++) send_item(ACT_BYTE, pkt_byte(p));
    calm = 1'b0;

    set_regs(rnd8(), rnd8(), 16'($urandom_range(2, 12)));
    run_mix(100);

    set_regs(rnd8(), rnd8(), 16'($urandom_range(13, 40)));
    calm = 1'b1;
    run_mix(100);
    calm = 1'b0;

    set_regs(rnd8(), rnd8(), 16'($urandom_range(65535)));
    hold_req <= 1'b1;
    run_mix(100);

    set_regs(RstAckedClass, rnd8(), RstTimeoutTicks);
    run_mix(100);

    in_ch.valid <= 1'b0;
    wait_cnt = 0;
    do begin
      @(posedge clk);
      wait_cnt++;
    end while (pending != 0 && wait_cnt < 5000);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
